>>> rtl/core/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared definitions of the binary to decimal ASCII unit
// Widths, character codes, register indexes, control FSM and handoff types.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

  // Field widths
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned ITER_W     = 5;

  // Default number of kept digits
  localparam int unsigned DEFAULT_MAX_DIGITS = 10;

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DIGIT_COUNT = 1'b0,
    CFG_APPEND_TERM = 1'b1
  } cfg_reg_e;

  // Converter sequencer
  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_e;

  // Live configuration
  typedef struct packed {
    logic [CNT_W-1:0] digit_count;
    logic             append_term;
  } bda_cfg_t;

  // Converted digits from the converter to the emitter
  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
  } bda_digits_t;

endpackage

`default_nettype wire

>>> rtl/core/bda_queue.sv
// ----------------------------------------------------------------------------
// bda_queue: two-entry input queue
// Accepts values from the input channel and holds them for the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_queue
  import bda_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    head_valid_o,
  output logic [VALUE_W-1:0]      head_value_o,
  input  wire logic               pop_i
);

  logic               head_v_q, tail_v_q;
  logic [VALUE_W-1:0] head_q, tail_q;
  logic               push;
  logic               pop;

  // full when the tail slot holds a word
  assign in_stall_o   = tail_v_q;
  assign push         = in_valid_i && !tail_v_q;
  assign pop          = pop_i && head_v_q;
  assign head_valid_o = head_v_q;
  assign head_value_o = head_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else if (pop) begin
      if (tail_v_q) begin
        tail_v_q <= push;
      end else begin
        head_v_q <= push;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_v_q <= 1'b1;
      end else begin
        tail_v_q <= 1'b1;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (tail_v_q) begin
        head_q <= tail_q;
        if (push) begin
          tail_q <= value_i;
        end
      end else if (push) begin
        head_q <= value_i;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_q <= value_i;
      end else begin
        tail_q <= value_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bda_conv.sv
// ----------------------------------------------------------------------------
// bda_conv: shift-and-add-3 binary to BCD converter
// Takes one value from the queue and converts it over 32 iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_conv
  import bda_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               src_valid_i,
  input  wire logic [VALUE_W-1:0] src_value_i,
  output logic                    pop_o,
  output bda_digits_t             digits_o,
  input  wire logic               digits_ready_i
);

  conv_state_e        state_q, state_d;
  logic [ITER_W-1:0]  iter_q;
  logic [VALUE_W-1:0] shift_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   bcd_adj;
  logic               last_iter;

  assign last_iter = (iter_q == {ITER_W{1'b1}});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CONV_IDLE: if (src_valid_i) state_d = CONV_RUN;
      CONV_RUN:  if (last_iter) state_d = CONV_DONE;
      CONV_DONE: if (digits_ready_i) state_d = CONV_IDLE;
      default:   state_d = CONV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o          = 1'b0;
    digits_o.valid = 1'b0;
    digits_o.bcd   = bcd_q;
    unique case (state_q)
      CONV_IDLE: pop_o = src_valid_i;
      CONV_RUN:  ;
      CONV_DONE: digits_o.valid = 1'b1;
      default:   ;
    endcase
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CONV_RUN) begin
        iter_q <= iter_q + 1'b1;
      end else begin
        iter_q <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == CONV_IDLE && src_valid_i) begin
      shift_q <= src_value_i;
      bcd_q   <= '0;
    end else if (state_q == CONV_RUN) begin
      {bcd_q, shift_q} <= {bcd_adj[BCD_W-2:0], shift_q, 1'b0};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit: ASCII character emitter
// Picks the digits to send, walks them MSD first and drives the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_emit
  import bda_pkg::*;
#(
  parameter int unsigned MaxDigits = DEFAULT_MAX_DIGITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bda_cfg_t    cfg_i,
  input  wire bda_digits_t digits_i,
  output logic             digits_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [CHAR_W-1:0] character_o,
  output logic             last_char_o
);

  localparam int unsigned DigW = $clog2(MaxDigits);

  logic [MaxDigits-1:0][3:0] digs_q;
  logic [DigW-1:0]           pos_q;
  logic                      active_q;
  logic                      term_q;
  logic                      out_valid_q;
  logic [CHAR_W-1:0]         char_q;
  logic                      last_q;

  logic [DigW-1:0]  top_idx;
  logic [CNT_W-1:0] sat_cnt;
  logic [CNT_W-1:0] sat_m1;
  logic [DigW-1:0]  start_idx;
  logic             load;
  logic             adv;

  // highest non-zero kept digit; zero gives one digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (digits_i.bcd[4*i +: 4] != 4'd0) begin
        top_idx = DigW'(i);
      end
    end
  end

  // fixed count saturates to the kept digits
  always_comb begin
    sat_cnt = (cfg_i.digit_count > CNT_W'(MaxDigits)) ? CNT_W'(MaxDigits)
                                                       : cfg_i.digit_count;
    sat_m1  = sat_cnt - 1'b1;
    start_idx = (cfg_i.digit_count == '0) ? top_idx : sat_m1[DigW-1:0];
  end

  assign digits_ready_o = !active_q;
  assign load           = digits_i.valid && !active_q;
  assign adv            = active_q && (!out_valid_q || !out_stall_i);

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        term_q   <= 1'b0;
      end else if (adv) begin
        if (term_q) begin
          active_q <= 1'b0;
          term_q   <= 1'b0;
        end else if (pos_q == '0) begin
          if (cfg_i.append_term) begin
            term_q <= 1'b1;
          end else begin
            active_q <= 1'b0;
          end
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit store, position and output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MaxDigits; i++) begin
        digs_q[i] <= digits_i.bcd[4*i +: 4];
      end
      pos_q <= start_idx;
    end else if (adv && !term_q && pos_q != '0) begin
      pos_q <= pos_q - 1'b1;
    end
    if (adv) begin
      if (term_q) begin
        char_q <= ASCII_NUL;
        last_q <= 1'b1;
      end else begin
        char_q <= ASCII_ZERO + {4'd0, digs_q[pos_q]};
        last_q <= (pos_q == '0) && !cfg_i.append_term;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: unsigned 32-bit value to decimal ASCII
// Queue, shift-and-add-3 converter and character emitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / value_i) takes one 32-bit
//   word per number. A two-entry queue sits in front of the converter.
//   Output channel (out_valid_o / out_stall_i / character_o / last_char_o)
//   gives one character per word, most significant digit first; the final
//   character of a number has last_char_o set (the NUL when one is added).
//   Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   index 0 digit count (0 = no leading zeros, 1..15 = fixed, saturating at
//   MaxDigits), index 1 append NUL. Write only while the unit is idle.
// Timing:
//   The first character of a number follows the queue slot, the converter
//   load, its 32 shift iterations, the handoff to the emitter and the
//   emitter output register. Emission of one number overlaps conversion of
//   the next.
//   A stalled output word holds; the emitter and converter back up behind it.
// Reset: clears queue, converter, emitter and registers (minimal mode, no NUL).
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit
  import bda_pkg::*;
#(
  parameter int unsigned MaxDigits = DEFAULT_MAX_DIGITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_W-1:0]    value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CHAR_W-1:0]          character_o,
  output logic                       last_char_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  bda_cfg_t           cfg_q;
  logic               head_valid;
  logic [VALUE_W-1:0] head_value;
  logic               pop;
  bda_digits_t        digits;
  logic               digits_ready;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DIGIT_COUNT: cfg_q.digit_count <= cfg_data_i;
        CFG_APPEND_TERM: cfg_q.append_term <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  bda_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .head_valid_o (head_valid),
    .head_value_o (head_value),
    .pop_i        (pop)
  );

  bda_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .src_valid_i    (head_valid),
    .src_value_i    (head_value),
    .pop_o          (pop),
    .digits_o       (digits),
    .digits_ready_i (digits_ready)
  );

  bda_emit #(
    .MaxDigits (MaxDigits)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .digits_i       (digits),
    .digits_ready_o (digits_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .last_char_o    (last_char_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/bda_port_checker.sv
// ----------------------------------------------------------------------------
// bda_port_checker: port-level checks of the decimal ASCII unit
// Watches the output channel and the character stream over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_port_checker
  import bda_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [CHAR_W-1:0] character_o,
  input wire logic              last_char_o
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o)
                                   && $stable(last_char_o))
    else $error("stalled output word changed");

  // only digits or NUL leave the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o >= ASCII_ZERO && character_o <= 8'h39)
                    || character_o == ASCII_NUL)
    else $error("character outside digit range");

  // NUL always closes a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == ASCII_NUL |-> last_char_o)
    else $error("terminator not marked last");

  // characters of one number follow without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_char_o |=> out_valid_o)
    else $error("gap inside a number");

endmodule

bind binary_to_decimal_ascii_unit bda_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_char_o (last_char_o)
);

`default_nettype wire

>>> test/binary_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit_tb: self-checking bench for the decimal ASCII unit
// Feeds 32-bit words, predicts each number's character string for the live
// digit count and NUL setting, and checks every emitted character in order.
// Runs a directed set of edge values, then random phases over several register
// settings, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

module binary_to_decimal_ascii_unit_tb;
  import bda_pkg::*;

  localparam int unsigned MAX_DIGITS    = DEFAULT_MAX_DIGITS;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_WORDS   = 40;
  localparam int unsigned HOLD_CYCLES   = 300;

  // one expected output character
  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } ascii_char_t;

  // Holds the live register copy and the characters still owed by the unit
  class ascii_scoreboard;
    logic [CNT_W-1:0] digit_count;
    logic             append_term;
    ascii_char_t      owed_chars[$];
    int unsigned      errors;

    function new();
      digit_count = '0;
      append_term = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DIGIT_COUNT) digit_count = data[CNT_W-1:0];
      else                        append_term = data[0];
    endfunction

    function int unsigned pending();
      return owed_chars.size();
    endfunction

    // Work out the characters that an accepted word will produce
    function void note_value(logic [VALUE_W-1:0] value);
      logic [3:0]         digs[MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 len;
      ascii_char_t        c;
      rest = value;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digs[i] = 4'(rest % 10);
        rest    = rest / 10;
      end
      if (digit_count == 0) begin
        // minimal form: zero still gives one digit
        len = 1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (digs[i] != 0) len = i + 1;
        end
      end else begin
        len = (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
      end
      for (int i = len - 1; i >= 0; i--) begin
        c.character = ASCII_ZERO + {4'b0, digs[i]};
        c.last_char = (i == 0) && !append_term;
        owed_chars.push_back(c);
      end
      if (append_term) begin
        c.character = ASCII_NUL;
        c.last_char = 1'b1;
        owed_chars.push_back(c);
      end
    endfunction

    // Compare an emitted character against the oldest one owed
    function void check_char(logic [CHAR_W-1:0] character, logic last_char);
      ascii_char_t exp;
      if (owed_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected word exp=none got char=%h last=%b", $time,
                 character, last_char);
        return;
      end
      exp = owed_chars.pop_front();
      if (character !== exp.character) begin
        errors++;
        $display("%0t: character mismatch exp=%h got=%h", $time, exp.character,
                 character);
      end
      if (last_char !== exp.last_char) begin
        errors++;
        $display("%0t: last_char mismatch exp=%b got=%b", $time, exp.last_char,
                 last_char);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [VALUE_W-1:0]    value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CHAR_W-1:0]     character_o;
  logic                  last_char_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ascii_scoreboard sb = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_off_req;
  int unsigned     hold_left;
  int unsigned     cycle_count;

  binary_to_decimal_ascii_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii_unit_tb: done, errors");
      $finish;
    end
  end

  // output side: random stall, or a long hold-off when asked
  initial hold_left = 0;
  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_char(character_o, last_char_o);
  end

  // Offer one word, idling first at random; returns on the accepting edge
  task automatic send_value(logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk); while (in_stall_o);
    sb.note_value(value);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // every word gives at least one character, so an empty list means idle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random word: full range, small, near powers of ten, shifted, all-0/all-1
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [63:0] pow;
    int unsigned k;
    pow = 64'd1;
    k   = $urandom_range(9);
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(999);
      2: begin
        repeat (k) pow = pow * 10;
        return VALUE_W'(pow + $urandom_range(2) - 1);
      end
      3: return $urandom() >> $urandom_range(31);
      default: return $urandom_range(1) ? '0 : '1;
    endcase
  endfunction

  logic [VALUE_W-1:0] edge_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd255, 32'd999, 32'd1000,
    32'd10000, 32'd65535, 32'd99999, 32'd999999999, 32'd1000000000,
    32'd1234567890, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };
  // digit counts per phase: extremes, the saturating codes and a few in between
  int unsigned phase_counts[PHASES] = '{10, 0, 15, 1, 11, 5, 0, 3, 10, 12, 2, 0};

  initial begin
    rst_ni        = 1'b0;
    in_valid_i   <= 1'b0;
    value_i      <= '0;
    out_stall_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_DIGIT_COUNT;
    cfg_data_i   <= '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 59;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // edge values in the reset setting (minimal, no NUL)
    foreach (edge_values[i]) send_value(edge_values[i]);

    // random phases: sender-light idling, then receiver-light, then none
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_DIGIT_COUNT, CFG_DATA_W'(phase_counts[p]));
      write_reg(CFG_APPEND_TERM, CFG_DATA_W'(p % 2));
      if (p < 4) begin
        send_idle_pct = 20;
        recv_idle_pct = 59;
      end else if (p < 8) begin
        send_idle_pct = 59;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long output hold-off with a busy sender: queue fills, input stalls
      if (p == 2) hold_off_req = 1'b1;
      repeat (PHASE_WORDS) send_value(pick_value());
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("binary_to_decimal_ascii_unit_tb: done, clean");
    end else begin
      $display("binary_to_decimal_ascii_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
